>>> hw/rtl/jssi_pkg.sv
// Shared types and constants for the JSON string and structural indexer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package jssi_pkg;

    localparam int MAX_LANES  = 8;
    localparam int CHUNK_W    = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 1;

    typedef logic [MAX_LANES-1:0]  t_lane_mask;
    typedef logic [CHUNK_W-1:0]    t_chunk;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_index;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Configuration register indexes
    localparam t_cfg_index CFG_START_IN_STRING = 4'd0;
    localparam t_cfg_index CFG_START_ESCAPED   = 4'd1;

    // Odd lane positions, used by the backslash run decode
    localparam t_lane_mask ODD_LANES = 8'hAA;

    // Character codes
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;

    // Per-lane byte classes of one chunk
    typedef struct packed {
        t_lane_mask quotes;
        t_lane_mask backslash;
        t_lane_mask structural;
    } t_class;

    // String and escape state between chunks
    typedef struct packed {
        logic in_string;
        logic escaped;
    } t_carry;

endpackage

>>> hw/rtl/jssi_if.sv
// Valid/ready channel interfaces for the indexer: text chunks in, masks out.
// Depends on jssi_pkg.
`timescale 1ns / 1ps

interface jssi_in_if;
    import jssi_pkg::*;

    logic   valid;
    logic   ready;
    t_chunk chunk_bytes;
    logic   restart;
    logic   last_chunk;

    modport source (output valid, output chunk_bytes, output restart, output last_chunk,
                    input ready);
    modport sink   (input valid, input chunk_bytes, input restart, input last_chunk,
                    output ready);
endinterface

interface jssi_out_if;
    import jssi_pkg::*;

    logic       valid;
    logic       ready;
    t_lane_mask in_string_mask;
    t_lane_mask structural_mask;
    logic       last_out;

    modport source (output valid, output in_string_mask, output structural_mask,
                    output last_out, input ready);
    modport sink   (input valid, input in_string_mask, input structural_mask,
                    input last_out, output ready);
endinterface

>>> hw/rtl/json_string_structural_indexer.sv
// Top level of the JSON string and structural indexer: input register,
// classify/scan logic, carry registers and result register.
// Depends on jssi_pkg, jssi_if, jssi_classify and jssi_scan.
//
//  Channel   Dir  Handshake          Payload
//  --------  ---  -----------------  ------------------------------------------
//  i_in_ch   in   valid/ready        chunk_bytes[63:0], restart, last_chunk
//  o_out_ch  out  valid/ready        in_string_mask[7:0], structural_mask[7:0],
//                                    last_out
//  i_cfg_*   in   write enable only  index 0 start_in_string, 1 start_escaped
//
// One chunk per cycle sustained while o_out_ch.ready stays high; a chunk's result
// passes through the input register, then the result register.
// The string and escape carries are one-bit registers updated as a chunk moves
// into the result register, so back-to-back chunks chain with no bubble.
// Reset (synchronous, active low) empties both stages and clears carries and
// configuration. A stalled output holds its result; the input register still
// takes one more chunk, after which i_in_ch.ready follows o_out_ch.ready.
`timescale 1ns / 1ps

module json_string_structural_indexer #(
    parameter int LANES = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    jssi_in_if.sink                i_in_ch,
    jssi_out_if.source             o_out_ch,
    input  logic                   i_cfg_wr_en,
    input  jssi_pkg::t_cfg_index   i_cfg_index,
    input  jssi_pkg::t_cfg_data    i_cfg_wdata
);
    import jssi_pkg::*;

    // configuration
    logic r_start_in_string;
    logic r_start_escaped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_in_string <= 1'b0;
            r_start_escaped   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_START_IN_STRING: r_start_in_string <= i_cfg_wdata[0];
                CFG_START_ESCAPED:   r_start_escaped   <= i_cfg_wdata[0];
                default: ;           // unknown index: ignored
            endcase
        end
    end

    // input stage
    logic   r_in_valid;
    t_chunk r_chunk;
    logic   r_restart;
    logic   r_last;
    logic   r_out_valid;
    logic   advance;
    logic   in_xfer;

    assign advance        = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready  = !r_in_valid || advance;
    assign in_xfer        = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_chunk   <= i_in_ch.chunk_bytes;
            r_restart <= i_in_ch.restart;
            r_last    <= i_in_ch.last_chunk;
        end
    end

    // carries: restart reloads from configuration before the chunk is scanned
    t_carry r_carry;
    t_carry carry_in;
    t_carry n_carry;
    t_class cls;
    t_lane_mask string_mask;

    always_comb begin
        if (r_restart) begin
            carry_in.in_string = r_start_in_string;
            carry_in.escaped   = r_start_escaped;
        end else begin
            carry_in = r_carry;
        end
    end

    jssi_classify #(.LANES(LANES)) u_classify (
        .i_chunk (r_chunk),
        .o_class (cls)
    );

    jssi_scan #(.LANES(LANES)) u_scan (
        .i_class  (cls),
        .i_carry  (carry_in),
        .o_inside (string_mask),
        .o_carry  (n_carry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else if (advance) begin
            r_carry <= n_carry;
        end
    end

    // result stage
    t_lane_mask r_inside;
    t_lane_mask r_structural;
    logic       r_last_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_inside     <= string_mask;
            r_structural <= cls.structural;
            r_last_out   <= r_last;
        end
    end

    assign o_out_ch.valid           = r_out_valid;
    assign o_out_ch.in_string_mask  = r_inside;
    assign o_out_ch.structural_mask = r_structural;
    assign o_out_ch.last_out        = r_last_out;

endmodule

>>> hw/rtl/jssi_classify.sv
// Byte classifier: flags quotes, backslashes and structural bytes per lane.
// Depends on jssi_pkg.
`timescale 1ns / 1ps

module jssi_classify #(
    parameter int LANES = 8
) (
    input  jssi_pkg::t_chunk i_chunk,
    output jssi_pkg::t_class o_class
);
    import jssi_pkg::*;

    localparam t_lane_mask LANE_MASK = t_lane_mask'((9'd1 << LANES) - 9'd1);

    t_lane_mask quotes;
    t_lane_mask backslash;
    t_lane_mask structural;

    always_comb begin
        logic [7:0] b;
        for (int i = 0; i < MAX_LANES; i++) begin
            b             = i_chunk[8*i +: 8];
            quotes[i]     = (b == CH_QUOTE);
            backslash[i]  = (b == CH_BACKSLASH);
            structural[i] = (b == CH_LBRACE)   || (b == CH_RBRACE) ||
                            (b == CH_LBRACKET) || (b == CH_RBRACKET) ||
                            (b == CH_COLON)    || (b == CH_COMMA);
        end
    end

    // lanes above LANES are dropped here
    assign o_class.quotes     = quotes & LANE_MASK;
    assign o_class.backslash  = backslash & LANE_MASK;
    assign o_class.structural = structural & LANE_MASK;

endmodule

>>> hw/rtl/jssi_scan.sv
// Escape and string scan over one chunk: odd backslash runs, then prefix XOR
// of the unescaped quotes seeded by the carried state. Depends on jssi_pkg.
`timescale 1ns / 1ps

module jssi_scan #(
    parameter int LANES = 8
) (
    input  jssi_pkg::t_class     i_class,
    input  jssi_pkg::t_carry     i_carry,
    output jssi_pkg::t_lane_mask o_inside,
    output jssi_pkg::t_carry     o_carry
);
    import jssi_pkg::*;

    localparam t_lane_mask LANE_MASK = t_lane_mask'((9'd1 << LANES) - 9'd1);
    localparam t_lane_mask ODD_MASK  = ODD_LANES & LANE_MASK;

    t_lane_mask esc_in;
    t_lane_mask potential;
    t_lane_mask run_code;
    t_lane_mask escaped;
    t_lane_mask toggles;
    t_lane_mask parity;
    t_lane_mask string_mask;

    assign esc_in    = {{(MAX_LANES-1){1'b0}}, i_carry.escaped};
    assign potential = i_class.backslash & ~esc_in & LANE_MASK;
    // carry ripple through each backslash run marks its parity
    assign run_code  = ((({potential[MAX_LANES-2:0], 1'b0} | ODD_MASK) - potential)
                        ^ ODD_MASK) & LANE_MASK;
    assign escaped   = (run_code ^ (i_class.backslash | esc_in)) & LANE_MASK;
    assign toggles   = i_class.quotes & ~escaped & LANE_MASK;

    always_comb begin
        parity[0] = toggles[0];
        for (int i = 1; i < MAX_LANES; i++) begin
            parity[i] = parity[i-1] ^ toggles[i];
        end
    end

    assign string_mask       = (parity ^ {MAX_LANES{i_carry.in_string}}) & LANE_MASK;
    assign o_inside          = string_mask;
    assign o_carry.in_string = string_mask[LANES-1];
    assign o_carry.escaped   = run_code[LANES-1] & i_class.backslash[LANES-1];

endmodule

>>> hw/rtl/jssi_checker.sv
// Port-level checks for the indexer, attached to the top level by bind.
// Depends on jssi_pkg and json_string_structural_indexer.
`timescale 1ns / 1ps

module jssi_port_checker #(
    parameter int LANES = 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input jssi_pkg::t_lane_mask i_in_string_mask,
    input jssi_pkg::t_lane_mask i_structural_mask
);
    import jssi_pkg::*;

    localparam t_lane_mask UNUSED_LANES = ~t_lane_mask'((9'd1 << LANES) - 9'd1);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // every accepted chunk is followed by a result offered on the output
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##2 i_out_valid)
        else $error("accepted chunk produced no result");

    // with no result pending the input side never stalls
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result stage");

    // lanes above LANES stay clear
    a_unused_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_in_string_mask & UNUSED_LANES) == '0) &&
                        ((i_structural_mask & UNUSED_LANES) == '0))
        else $error("mask bit set beyond the active lanes");

endmodule

bind json_string_structural_indexer jssi_port_checker #(.LANES(LANES)) u_jssi_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_ch.valid),
    .i_in_ready        (i_in_ch.ready),
    .i_out_valid       (o_out_ch.valid),
    .i_out_ready       (o_out_ch.ready),
    .i_in_string_mask  (o_out_ch.in_string_mask),
    .i_structural_mask (o_out_ch.structural_mask)
);

>>> sim/jssi_checker.sv
`timescale 1ns / 1ps
// Checker for json_string_structural_indexer: predicts the masks of every chunk
// transfer and compares them with the output transfers. Uses jssi_pkg, jssi_if.

module jssi_checker #(
    parameter int LANES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    jssi_in_if                   i_in_mon,
    jssi_out_if                  i_out_mon,
    input  logic                 i_cfg_wr_en,
    input  jssi_pkg::t_cfg_index i_cfg_index,
    input  jssi_pkg::t_cfg_data  i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending
);
    import jssi_pkg::*;

    localparam logic [LANES-1:0] ODD = ODD_LANES[LANES-1:0];
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_lane_mask in_string;
        t_lane_mask structural;
        logic       last_flag;
    } t_masks;

    t_masks expected_masks[$];
    logic   start_in_string = 1'b0;
    logic   start_escaped   = 1'b0;
    logic   string_carry    = 1'b0;
    logic   escape_carry    = 1'b0;
    int     mismatch_count  = 0;

    assign o_fail_count = mismatch_count;

    // Masks of one chunk; advances the string and escape carries.
    function automatic t_masks scan_chunk(t_chunk text, logic restart, logic last_flag);
        logic [LANES-1:0] quotes, backslash, structural;
        logic [LANES-1:0] potential, run_code, escaped, escape, toggles, string_mask;
        logic [7:0]       ch;
        logic             parity;
        t_masks           r;

        if (restart) begin
            string_carry = start_in_string;
            escape_carry = start_escaped;
        end
        quotes     = '0;
        backslash  = '0;
        structural = '0;
        for (int i = 0; i < LANES; i++) begin
            ch            = text[8*i +: 8];
            quotes[i]     = (ch == CH_QUOTE);
            backslash[i]  = (ch == CH_BACKSLASH);
            structural[i] = (ch == CH_LBRACE) || (ch == CH_RBRACE) || (ch == CH_LBRACKET) ||
                            (ch == CH_RBRACKET) || (ch == CH_COLON) || (ch == CH_COMMA);
        end
        // odd-length backslash runs, a run may continue from the last chunk;
        // a carried escape only blocks lane 0 from starting a run
        potential    = backslash & ~LANES'(escape_carry);
        run_code     = (((potential << 1) | ODD) - potential) ^ ODD;
        escaped      = run_code ^ (backslash | LANES'(escape_carry));
        escape       = run_code & backslash;
        escape_carry = escape[LANES-1];
        // unescaped quotes toggle the string state lane by lane
        toggles = quotes & ~escaped;
        parity  = string_carry;
        for (int i = 0; i < LANES; i++) begin
            parity         = parity ^ toggles[i];
            string_mask[i] = parity;
        end
        string_carry = string_mask[LANES-1];

        r.in_string  = t_lane_mask'(string_mask);
        r.structural = t_lane_mask'(structural);
        r.last_flag  = last_flag;
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [7:0] want, logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t mismatch %s: expected %02h actual %02h", $realtime, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_masks got;
        t_masks want;

        if (!i_rst_n) begin
            start_in_string = 1'b0;
            start_escaped   = 1'b0;
            string_carry    = 1'b0;
            escape_carry    = 1'b0;
            expected_masks.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_START_IN_STRING: start_in_string = i_cfg_wdata[0];
                    CFG_START_ESCAPED:   start_escaped   = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_masks.push_back(scan_chunk(i_in_mon.chunk_bytes, i_in_mon.restart,
                                                    i_in_mon.last_chunk));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.in_string  = i_out_mon.in_string_mask;
                got.structural = i_out_mon.structural_mask;
                got.last_flag  = i_out_mon.last_out;
                if (expected_masks.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t output transfer with no chunk outstanding: %p",
                                 $realtime, got);
                    end
                end else begin
                    want = expected_masks.pop_front();
                    if (got.in_string !== want.in_string)
                        note_mismatch("in_string_mask", want.in_string, got.in_string);
                    if (got.structural !== want.structural)
                        note_mismatch("structural_mask", want.structural, got.structural);
                    if (got.last_flag !== want.last_flag)
                        note_mismatch("last_out", 8'(want.last_flag), 8'(got.last_flag));
                end
            end
        end
        o_pending <= expected_masks.size();
    end

endmodule

>>> sim/json_string_structural_indexer_tb.sv
`timescale 1ns / 1ps
// Testbench top for json_string_structural_indexer: clock, reset, chunk and
// configuration stimulus, output back-pressure and the verdict. Uses jssi_checker.

module json_string_structural_indexer_tb;
    import jssi_pkg::*;

    localparam int LANES              = 8;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int RANDOM_PHASE_ITEMS = 470;
    localparam int RANDOM_PHASES      = 4;
    localparam int SETTLE_CYCLES      = 4;   // result register sits two stages deep
    localparam logic [7:0] PAD_BYTE   = 8'h20;
    localparam t_cfg_index FIRST_UNUSED_INDEX = t_cfg_index'(CFG_START_ESCAPED + 1);
    localparam logic [7:0] STRUCT_CHARS [6] =
        '{CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COLON, CH_COMMA};

    // restart settings of the random phases; the last one runs without idling
    localparam bit PHASE_IN_STRING [RANDOM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0};
    localparam bit PHASE_ESCAPED   [RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0};

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_wr_en;
    t_cfg_index cfg_index;
    t_cfg_data  cfg_wdata;
    int         fail_count;
    int         pending;
    bit         calm = 1'b0;   // no idling on either side once set
    int         cycle_count = 0;

    jssi_in_if  in_ch ();
    jssi_out_if out_ch ();

    json_string_structural_indexer #(
        .LANES(LANES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata)
    );

    jssi_checker #(
        .LANES(LANES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("json_string_structural_indexer verification failed");
        $finish;
    end

    // Pack up to eight text characters, first one in the low byte, pad with spaces.
    function automatic t_chunk text_chunk(string s);
        t_chunk c;
        c = {MAX_LANES{PAD_BYTE}};
        for (int i = 0; i < s.len() && i < MAX_LANES; i++) c[8*i +: 8] = s[i];
        return c;
    endfunction

    // Byte mix leaning on quotes, backslashes and structurals so strings
    // open and close often and escapes hit every lane.
    function automatic logic [7:0] json_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return CH_QUOTE;
        if (pick < 38) return CH_BACKSLASH;
        if (pick < 60) return STRUCT_CHARS[$urandom_range(0, 5)];
        if (pick < 95) return 8'($urandom_range(8'h20, 8'h7E));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_chunk random_chunk();
        t_chunk c;
        if ($urandom_range(0, 6) == 0) return {$urandom, $urandom};   // raw noise
        for (int i = 0; i < MAX_LANES; i++) begin
            // repeats build longer backslash and quote runs
            if (i > 0 && $urandom_range(0, 3) == 0) c[8*i +: 8] = c[8*(i-1) +: 8];
            else c[8*i +: 8] = json_byte();
        end
        return c;
    endfunction

    // One chunk transfer; valid stays high on return.
    task automatic push_chunk(t_chunk text, logic restart, logic last_flag);
        in_ch.valid       <= 1'b1;
        in_ch.chunk_bytes <= text;
        in_ch.restart     <= restart;
        in_ch.last_chunk  <= last_flag;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Hold off until every chunk in flight has come out, then let the
    // pipeline settle. The first edge lets the checker count the last transfer.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the block idle. Optionally pokes an unmapped index,
    // which must leave both registers alone.
    task automatic set_restart_state(logic in_string, logic escaped, bit poke_unused);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_START_IN_STRING;
        cfg_wdata <= in_string;
        @(posedge i_clk);
        cfg_index <= CFG_START_ESCAPED;
        cfg_wdata <= escaped;
        @(posedge i_clk);
        if (poke_unused) begin
            cfg_index <= t_cfg_index'($urandom_range(FIRST_UNUSED_INDEX, 2**CFG_IDX_W - 1));
            cfg_wdata <= '1;
            @(posedge i_clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Output side: random ready bursts, steady in the calm phase.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= CFG_START_IN_STRING;
        cfg_wdata         <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.chunk_bytes <= '0;
        in_ch.restart     <= 1'b0;
        in_ch.last_chunk  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: plain restart state, unmapped index poked ----
        set_restart_state(1'b0, 1'b0, 1'b1);
        push_chunk(text_chunk("{\"ab\":1,"), 1'b1, 1'b0);
        push_chunk(text_chunk("\"x\\\"y\\\\\""), 1'b0, 1'b0);  // escaped quote, even run
        push_chunk('0, 1'b0, 1'b0);
        push_chunk('1, 1'b0, 1'b0);
        push_chunk(text_chunk("[]{}:,[]"), 1'b0, 1'b0);
        push_chunk(text_chunk("\"\"\"\"\"\"\"\""), 1'b0, 1'b0);
        push_chunk(text_chunk("\\\\\\\\\\\\\\\\"), 1'b0, 1'b0);   // eight backslashes
        push_chunk(text_chunk("\\\\\\\\\\\\\\\""), 1'b0, 1'b0);   // seven then a quote
        // string open and a lone backslash in the top lane: both carries set
        push_chunk(text_chunk("\"abcdef\\"), 1'b0, 1'b0);
        // leading quote escaped across the chunk boundary; last chunk flagged
        push_chunk(text_chunk("\"],:\"{ x"), 1'b0, 1'b1);
        // last chunk does not clear the carries
        push_chunk(text_chunk("ab\"cd\"ef"), 1'b0, 1'b0);
        push_chunk({$urandom, $urandom}, 1'b0, 1'b1);

        // ---- directed: restart into a string with the first byte escaped ----
        drain();
        set_restart_state(1'b1, 1'b1, 1'b0);
        push_chunk(text_chunk("\"abc\"de,"), 1'b1, 1'b0);
        push_chunk(text_chunk("x:y\"z\\"), 1'b0, 1'b0);

        drain();
        set_restart_state(1'b1, 1'b0, 1'b0);
        push_chunk(text_chunk("abc\"d{}e"), 1'b1, 1'b0);

        drain();
        set_restart_state(1'b0, 1'b1, 1'b0);
        push_chunk(text_chunk("\\\"ab\"\"c"), 1'b1, 1'b0);
        push_chunk(text_chunk("\\\\\\\\\\\\\\\""), 1'b1, 1'b1);

        // ---- random phases, one restart setting each ----
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            if (p == RANDOM_PHASES - 1) calm = 1'b1;
            set_restart_state(PHASE_IN_STRING[p], PHASE_ESCAPED[p], p == RANDOM_PHASES - 1);
            push_chunk(random_chunk(), 1'b1, 1'b0);
            for (int n = 0; n < RANDOM_PHASE_ITEMS; n++) begin
                sender_gap();
                push_chunk(random_chunk(), $urandom_range(0, 24) == 0,
                           $urandom_range(0, 7) == 0);
                // one mid-phase hold-off with the pipeline fully drained
                if (p == 0 && n == RANDOM_PHASE_ITEMS / 2) drain();
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("json_string_structural_indexer verification clean");
        end else begin
            $display("json_string_structural_indexer verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/jssi_pkg.sv
hw/rtl/jssi_if.sv
hw/rtl/jssi_classify.sv
hw/rtl/jssi_scan.sv
hw/rtl/json_string_structural_indexer.sv
hw/rtl/jssi_checker.sv
sim/jssi_checker.sv
sim/json_string_structural_indexer_tb.sv
